FILE: rtl/cscl_pkg.sv
// ----------------------------------------------------------------------------
// cscl_pkg: shared types and constants of the serial command link
// Request kinds, frame lengths, register reset values and the structs that
// pass between the front end, the request queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cscl_pkg;

   // Request kinds
   localparam logic KIND_RX_BYTE = 1'b0;
   localparam logic KIND_TX_READY = 1'b1;

   // Register indexes, as selected by paddr[2]
   localparam logic REG_SYNC_BYTE = 1'b0;
   localparam logic REG_PULSE_OFFSET = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] SYNC_RESET = 8'hAA;
   localparam logic [15:0] OFFSET_RESET = 16'h07CF;

   // Receive framing: the checksum byte sits at this position
   localparam logic [1:0] RX_CHECK_POS = 2'd3;

   // Telemetry reply framing
   localparam int TX_FRAME_LEN = 10;
   localparam int TX_POS_W = 4;
   localparam logic [TX_POS_W-1:0] TX_FIRST_POS = TX_POS_W'(1);
   localparam logic [TX_POS_W-1:0] TX_LAST_POS = TX_POS_W'(TX_FRAME_LEN - 1);
   localparam int TEL_WORDS = 4;

   // Request queue between front and back end
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [15:0] pulse_offset;
   } cfg_type;

   typedef struct packed {
      logic kind;
      logic is_sync;
      logic [7:0] rx_byte;
      logic [9:0] adc_ch0;
      logic [9:0] adc_ch1;
      logic [15:0] encoder_count;
      logic [15:0] mag_x;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic tx_valid;
      logic [7:0] tx_byte;
      logic tx_last;
      logic pulse_valid;
      logic [15:0] pulse_width;
      logic frame_rejected;
   } result_type;

endpackage

FILE: rtl/checksummed_serial_command_link.sv
// ----------------------------------------------------------------------------
// checksummed_serial_command_link: framed servo command receiver with reply
// Frames 4-byte checksummed commands; each good one opens a 10-byte telemetry
// reply with the sync byte, and each transmitter-ready request sends the next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Every request, received byte or transmitter ready, yields exactly one
// response. The block sustains one request per clock while the response side
// does not stall: a two-entry queue takes requests while the back end advances
// its framing state one request per cycle, and that state update sets the
// rate. An accepted request is written into the queue, then taken into the
// output register that drives the response outputs. Stalling the response
// side fills the queue and then raises req_stall. The sync byte (address 0)
// and the pulse offset (address 4) must be written over the APB port only
// while the block is idle; the block itself does not enforce this. paddr[2]
// selects the register.
module checksummed_serial_command_link (
   input logic clock,
   input logic reset,
   // Request channel
   input logic req_valid,
   output logic req_stall,
   input logic req_type,
   input logic [7:0] req_rx_byte,
   input logic [9:0] req_adc_ch0,
   input logic [9:0] req_adc_ch1,
   input logic [15:0] req_encoder_count,
   input logic [15:0] req_mag_x,
   // Response channel
   output logic rsp_valid,
   input logic rsp_stall,
   output logic rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic rsp_tx_last,
   output logic rsp_pulse_valid,
   output logic [15:0] rsp_pulse_width,
   output logic rsp_frame_rejected,
   // Configuration port
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [cscl_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [cscl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cscl_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);
   import cscl_pkg::*;

   logic [7:0] sync_ff;
   logic [15:0] offset_ff;
   logic csr_write;
   cfg_type cfg;
   cmd_type head;
   queue_status_type q_status;
   logic pop;
   result_type rsp;

   // Configuration registers: the write lands on the access cycle
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_SYNC_BYTE: sync_ff <= pwdata[7:0];
            REG_PULSE_OFFSET: offset_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_SYNC_BYTE: prdata = {24'd0, sync_ff};
         REG_PULSE_OFFSET: prdata = {16'd0, offset_ff};
         default: prdata = '0;
      endcase
   end

   assign cfg.sync_byte = sync_ff;
   assign cfg.pulse_offset = offset_ff;

   // Front end: tag and queue requests
   cscl_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_rx_byte(req_rx_byte),
      .req_adc_ch0(req_adc_ch0),
      .req_adc_ch1(req_adc_ch1),
      .req_encoder_count(req_encoder_count),
      .req_mag_x(req_mag_x),
      .cfg(cfg),
      .pop(pop),
      .head(head),
      .status(q_status)
   );

   // Back end: advance framing and reply state, register the response
   cscl_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .head(head),
      .status(q_status),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp(rsp)
   );

   assign rsp_tx_valid = rsp.tx_valid;
   assign rsp_tx_byte = rsp.tx_byte;
   assign rsp_tx_last = rsp.tx_last;
   assign rsp_pulse_valid = rsp.pulse_valid;
   assign rsp_pulse_width = rsp.pulse_width;
   assign rsp_frame_rejected = rsp.frame_rejected;

   // A good command always opens the reply with the configured sync byte
   a_pulse_opens_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pulse_valid) |-> (rsp_tx_valid && rsp_tx_byte == sync_ff))
      else $error("good command without sync byte reply");

   // A queued request with a free output register is delivered next cycle
   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      (!q_status.empty && (!rsp_valid || !rsp_stall)) |=> rsp_valid)
      else $error("queued request not delivered");

   // The queue never reads as both full and empty
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue status inconsistent");

endmodule

FILE: rtl/cscl_front.sv
// ----------------------------------------------------------------------------
// cscl_front: request intake and classification
// Tags each request with its kind and a sync-byte match, and holds it in a
// short queue until the back end takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cscl_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_type,
   input logic [7:0] req_rx_byte,
   input logic [9:0] req_adc_ch0,
   input logic [9:0] req_adc_ch1,
   input logic [15:0] req_encoder_count,
   input logic [15:0] req_mag_x,
   input cscl_pkg::cfg_type cfg,
   input logic pop,
   output cscl_pkg::cmd_type head,
   output cscl_pkg::queue_status_type status
);
   import cscl_pkg::*;

   cmd_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   cmd_type incoming;
   logic push;
   logic do_pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + QPTR_W'(1);
   endfunction

   always_comb begin
      incoming.kind = req_type;
      incoming.is_sync = (req_rx_byte == cfg.sync_byte);
      incoming.rx_byte = req_rx_byte;
      incoming.adc_ch0 = req_adc_ch0;
      incoming.adc_ch1 = req_adc_ch1;
      incoming.encoder_count = req_encoder_count;
      incoming.mag_x = req_mag_x;
   end

   assign status.full = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign req_stall = status.full;
   assign push = req_valid && !status.full;
   assign do_pop = pop && !status.empty;
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

FILE: rtl/cscl_back.sv
// ----------------------------------------------------------------------------
// cscl_back: command framing and telemetry reply engine
// Takes one queued request a cycle unless the response stalls, advances the
// receive and transmit state, registers the result for the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cscl_back (
   input logic clock,
   input logic reset,
   input cscl_pkg::cfg_type cfg,
   input cscl_pkg::cmd_type head,
   input cscl_pkg::queue_status_type status,
   output logic pop,
   output logic rsp_valid,
   input logic rsp_stall,
   output cscl_pkg::result_type rsp
);
   import cscl_pkg::*;

   logic [1:0] rx_position_ff, rx_position_in;
   logic [7:0] rx_sum_ff, rx_sum_in;
   logic [15:0] rx_pulse_ff, rx_pulse_in;
   logic tx_active_ff, tx_active_in;
   logic [TX_POS_W-1:0] tx_position_ff, tx_position_in;
   logic [7:0] tx_sum_ff, tx_sum_in;
   logic [15:0] tel_ff [TEL_WORDS];
   logic snapshot;
   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic [TX_POS_W-1:0] tel_k;
   logic [15:0] tel_word;
   logic [7:0] tel_byte;

   // Take the next request whenever the output register is free or draining
   assign pop = !status.empty && (!rsp_valid_ff || !rsp_stall);

   assign tel_k = tx_position_ff - TX_FIRST_POS;
   assign tel_word = tel_ff[tel_k[2:1]];
   assign tel_byte = tel_k[0] ? tel_word[15:8] : tel_word[7:0];

   always_comb begin
      rx_position_in = rx_position_ff;
      rx_sum_in = rx_sum_ff;
      rx_pulse_in = rx_pulse_ff;
      tx_active_in = tx_active_ff;
      tx_position_in = tx_position_ff;
      tx_sum_in = tx_sum_ff;
      snapshot = 1'b0;
      rsp_in = '0;
      if (head.kind == KIND_RX_BYTE) begin
         if (rx_position_ff == 2'd0) begin
            if (head.is_sync) begin
               rx_sum_in = head.rx_byte;
               rx_position_in = 2'd1;
            end
         end else if (rx_position_ff < RX_CHECK_POS) begin
            if (rx_position_ff == 2'd1) begin
               rx_pulse_in[7:0] = head.rx_byte;
            end else begin
               rx_pulse_in[15:8] = head.rx_byte;
            end
            rx_sum_in = rx_sum_ff + head.rx_byte;
            rx_position_in = rx_position_ff + 2'd1;
         end else begin
            if (rx_sum_ff == head.rx_byte) begin
               rsp_in.pulse_valid = 1'b1;
               rsp_in.pulse_width = rx_pulse_ff + cfg.pulse_offset;
               rsp_in.tx_valid = 1'b1;
               rsp_in.tx_byte = cfg.sync_byte;
               snapshot = 1'b1;
               tx_active_in = 1'b1;
               tx_position_in = TX_FIRST_POS;
               tx_sum_in = cfg.sync_byte;
            end else begin
               rsp_in.frame_rejected = 1'b1;
            end
            rx_position_in = 2'd0;
            rx_sum_in = '0;
         end
      end else if (tx_active_ff) begin
         rsp_in.tx_valid = 1'b1;
         if (tx_position_ff >= TX_FIRST_POS && tx_position_ff < TX_LAST_POS) begin
            rsp_in.tx_byte = tel_byte;
            tx_sum_in = tx_sum_ff + tel_byte;
            tx_position_in = tx_position_ff + TX_POS_W'(1);
         end else begin
            rsp_in.tx_byte = tx_sum_ff;
            rsp_in.tx_last = 1'b1;
            tx_active_in = 1'b0;
            tx_position_in = TX_FIRST_POS;
            tx_sum_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_position_ff <= '0;
         rx_sum_ff <= '0;
         rx_pulse_ff <= '0;
         tx_active_ff <= 1'b0;
         tx_position_ff <= TX_FIRST_POS;
         tx_sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            rx_position_ff <= rx_position_in;
            rx_sum_ff <= rx_sum_in;
            rx_pulse_ff <= rx_pulse_in;
            tx_active_ff <= tx_active_in;
            tx_position_ff <= tx_position_in;
            tx_sum_ff <= tx_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
      if (pop && snapshot) begin
         tel_ff[0] <= {6'd0, head.adc_ch0};
         tel_ff[1] <= {6'd0, head.adc_ch1};
         tel_ff[2] <= head.encoder_count;
         tel_ff[3] <= head.mag_x;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

FILE: bench/tb_checksummed_serial_command_link.sv
// ----------------------------------------------------------------------------
// tb_checksummed_serial_command_link: self-checking bench of the command link
// Walks a directed table of framing cases, then random command frames, reply
// reads and noise under several sync and offset settings. A behavioral model
// inside the bench predicts every response, and a monitor compares them field
// by field. Random idle gaps and stall bursts disturb both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_checksummed_serial_command_link;

   import cscl_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;

   // One request as the bench sees it
   typedef struct {
      logic kind;
      logic [7:0] rx_byte;
      logic [9:0] adc_ch0;
      logic [9:0] adc_ch1;
      logic [15:0] encoder_count;
      logic [15:0] mag_x;
   } link_request_type;

   // One row of the directed table: a request and, where typed, its response
   typedef struct {
      link_request_type item;
      bit typed;
      result_type want;
   } directed_row_type;

   // Responses that can be read straight off the framing rules
   localparam result_type NO_OUTPUT = '0;
   localparam result_type CMD_DEFAULT_OFFSET =
      result_type'({1'b1, 8'hAA, 1'b0, 1'b1, 16'h07CF, 1'b0});
   localparam result_type CMD_MAX_PULSE =
      result_type'({1'b1, 8'hAA, 1'b0, 1'b1, 16'h07CE, 1'b0});
   localparam result_type CMD_REJECTED =
      result_type'({1'b0, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1});

   logic clock;
   logic reset;

   logic req_valid;
   logic req_stall;
   logic req_type;
   logic [7:0] req_rx_byte;
   logic [9:0] req_adc_ch0;
   logic [9:0] req_adc_ch1;
   logic [15:0] req_encoder_count;
   logic [15:0] req_mag_x;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic rsp_tx_last;
   logic rsp_pulse_valid;
   logic [15:0] rsp_pulse_width;
   logic rsp_frame_rejected;

   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // Responses still owed by the block, oldest first
   result_type pending_responses[$];
   int errors = 0;
   bit quiet = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;

   directed_row_type directed[25];

   // Link model state: register copies, receive framing and reply progress
   logic [7:0] cfg_sync;
   logic [15:0] cfg_offset;
   logic [1:0] frame_pos;
   logic [7:0] frame_sum;
   logic [15:0] frame_pulse;
   logic reply_busy;
   logic [3:0] reply_pos;
   logic [7:0] reply_sum;
   logic [15:0] snap_words[TEL_WORDS];

   checksummed_serial_command_link u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_rx_byte(req_rx_byte),
      .req_adc_ch0(req_adc_ch0),
      .req_adc_ch1(req_adc_ch1),
      .req_encoder_count(req_encoder_count),
      .req_mag_x(req_mag_x),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last),
      .rsp_pulse_valid(rsp_pulse_valid),
      .rsp_pulse_width(rsp_pulse_width),
      .rsp_frame_rejected(rsp_frame_rejected),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Put the model back in its post-reset state
   task automatic reset_link_model();
      cfg_sync = SYNC_RESET;
      cfg_offset = OFFSET_RESET;
      frame_pos = 2'd0;
      frame_sum = 8'd0;
      frame_pulse = 16'd0;
      reply_busy = 1'b0;
      reply_pos = TX_FIRST_POS;
      reply_sum = 8'd0;
      for (int i = 0; i < TEL_WORDS; i++) begin
         snap_words[i] = 16'd0;
      end
   endtask

   // Advance the link model by one request and return the response it owes
   task automatic advance_link(input link_request_type it, output result_type r);
      logic [3:0] k;
      logic [15:0] w;
      logic [7:0] v;
      r = NO_OUTPUT;
      if (it.kind == KIND_RX_BYTE) begin
         if (frame_pos == 2'd0) begin
            // Anything but the sync byte is dropped while hunting for a frame
            if (it.rx_byte == cfg_sync) begin
               frame_sum = it.rx_byte;
               frame_pos = 2'd1;
            end
         end else if (frame_pos != RX_CHECK_POS) begin
            if (frame_pos == 2'd1) begin
               frame_pulse[7:0] = it.rx_byte;
            end else begin
               frame_pulse[15:8] = it.rx_byte;
            end
            frame_sum = frame_sum + it.rx_byte;
            frame_pos = frame_pos + 2'd1;
         end else begin
            if (frame_sum == it.rx_byte) begin
               // Good command: emit the compare value, snapshot and restart the reply
               r.pulse_valid = 1'b1;
               r.pulse_width = frame_pulse + cfg_offset;
               snap_words[0] = {6'd0, it.adc_ch0};
               snap_words[1] = {6'd0, it.adc_ch1};
               snap_words[2] = it.encoder_count;
               snap_words[3] = it.mag_x;
               reply_busy = 1'b1;
               reply_pos = TX_FIRST_POS;
               reply_sum = cfg_sync;
               r.tx_valid = 1'b1;
               r.tx_byte = cfg_sync;
            end else begin
               r.frame_rejected = 1'b1;
            end
            frame_pos = 2'd0;
            frame_sum = 8'd0;
         end
      end else if (reply_busy) begin
         if (reply_pos >= TX_FIRST_POS && reply_pos < TX_LAST_POS) begin
            k = reply_pos - TX_FIRST_POS;
            w = snap_words[k[2:1]];
            v = k[0] ? w[15:8] : w[7:0];
            r.tx_valid = 1'b1;
            r.tx_byte = v;
            reply_sum = reply_sum + v;
            reply_pos = reply_pos + 4'd1;
         end else begin
            r.tx_valid = 1'b1;
            r.tx_byte = reply_sum;
            r.tx_last = 1'b1;
            reply_busy = 1'b0;
            reply_pos = TX_FIRST_POS;
            reply_sum = 8'd0;
         end
      end
   endtask

   function automatic directed_row_type mk_row(input logic kind, input logic [7:0] b,
         input logic [9:0] a0, input logic [9:0] a1, input logic [15:0] enc,
         input logic [15:0] mag, input bit typed, input result_type want);
      directed_row_type row;
      row.item.kind = kind;
      row.item.rx_byte = b;
      row.item.adc_ch0 = a0;
      row.item.adc_ch1 = a1;
      row.item.encoder_count = enc;
      row.item.mag_x = mag;
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   // Build a request with fresh telemetry, now and then pinned to an extreme
   function automatic link_request_type make_request(input logic kind,
         input logic [7:0] b);
      link_request_type it;
      int pick;
      pick = $urandom_range(0, 9);
      it.kind = kind;
      it.rx_byte = b;
      if (pick == 0) begin
         it.adc_ch0 = '0;
         it.adc_ch1 = '0;
         it.encoder_count = '0;
         it.mag_x = '0;
      end else if (pick == 1) begin
         it.adc_ch0 = '1;
         it.adc_ch1 = '1;
         it.encoder_count = '1;
         it.mag_x = '1;
      end else begin
         it.adc_ch0 = 10'($urandom);
         it.adc_ch1 = 10'($urandom);
         it.encoder_count = 16'($urandom);
         it.mag_x = 16'($urandom);
      end
      return it;
   endfunction

   function automatic logic [7:0] pick_byte();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Offer one request, hold it until accepted, then log what it must produce.
   // Call right after a rising edge.
   task automatic send_request(input link_request_type it, input bit typed,
         input result_type want);
      result_type got;
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= it.kind;
      req_rx_byte <= it.rx_byte;
      req_adc_ch0 <= it.adc_ch0;
      req_adc_ch1 <= it.adc_ch1;
      req_encoder_count <= it.encoder_count;
      req_mag_x <= it.mag_x;
      // Hold the payload through any stall; stall read here is the pre-edge value
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_link(it, got);
      pending_responses.push_back(typed ? want : got);
   endtask

   task automatic send_random(input logic kind, input logic [7:0] b);
      send_request(make_request(kind, b), 1'b0, NO_OUTPUT);
   endtask

   // APB write: setup cycle, then access until pready. Call right after an edge.
   task automatic write_register(input logic idx, input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_SYNC_BYTE) begin
         cfg_sync = value[7:0];
      end else begin
         cfg_offset = value[15:0];
      end
   endtask

   // Drop valid and wait until every owed response is back, plus the pipeline depth
   task automatic drain_link();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [7:0] sync, input logic [15:0] offset);
      logic [CSR_DATA_W-1:0] junk;
      // Fill the unused upper bits with noise; the block must ignore them
      junk = $urandom;
      write_register(REG_SYNC_BYTE, {junk[31:8], sync});
      junk = $urandom;
      write_register(REG_PULSE_OFFSET, {junk[31:16], offset});
   endtask

   // Mostly well-formed commands followed by reply reads, with noise mixed in
   task automatic run_random_phase(input int budget);
      int done;
      int pick;
      int n;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] sum;
      done = 0;
      while (done < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            lo = pick_byte();
            hi = pick_byte();
            sum = cfg_sync + lo + hi;
            // Corrupt the checksum on some frames
            if (pick >= 55) begin
               sum = sum ^ 8'($urandom_range(1, 255));
            end
            send_random(KIND_RX_BYTE, cfg_sync);
            send_random(KIND_RX_BYTE, lo);
            send_random(KIND_RX_BYTE, hi);
            send_random(KIND_RX_BYTE, sum);
            n = $urandom_range(0, 11);
            repeat (n) send_random(KIND_TX_READY, 8'($urandom));
            done += 4 + n;
         end else if (pick < 75) begin
            send_random(KIND_RX_BYTE, 8'($urandom));
            done += 1;
         end else if (pick < 85) begin
            send_random(KIND_TX_READY, 8'($urandom));
            done += 1;
         end else if (pick < 95) begin
            // Truncated frame: the next frame lands in the middle of this one
            n = $urandom_range(1, 2);
            send_random(KIND_RX_BYTE, cfg_sync);
            repeat (n) send_random(KIND_RX_BYTE, pick_byte());
            done += 1 + n;
         end else begin
            send_random(1'($urandom), 8'($urandom));
            done += 1;
         end
      end
      // Leave a frame open so the next sync setting changes mid-frame
      send_random(KIND_RX_BYTE, cfg_sync);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
         input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
         errors++;
      end
   endtask

   // Response side: raise the stall in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each accepted response against the oldest owed one
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_responses.size() == 0) begin
            $display("%0t: unexpected response expected none actual tx_byte %h pulse %h",
               $realtime, rsp_tx_byte, rsp_pulse_width);
            errors++;
         end else begin
            want = pending_responses.pop_front();
            compare_field("tx_valid", 16'(want.tx_valid), 16'(rsp_tx_valid));
            compare_field("tx_byte", 16'(want.tx_byte), 16'(rsp_tx_byte));
            compare_field("tx_last", 16'(want.tx_last), 16'(rsp_tx_last));
            compare_field("pulse_valid", 16'(want.pulse_valid), 16'(rsp_pulse_valid));
            compare_field("pulse_width", want.pulse_width, rsp_pulse_width);
            compare_field("frame_rejected", 16'(want.frame_rejected),
               16'(rsp_frame_rejected));
         end
      end
   end

   // End the run if neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0)
            || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= KIND_RX_BYTE;
      req_rx_byte <= 8'd0;
      req_adc_ch0 <= 10'd0;
      req_adc_ch1 <= 10'd0;
      req_encoder_count <= 16'd0;
      req_mag_x <= 16'd0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      reset_link_model();

      // Directed table: idle ready, dropped byte, default offset, command in
      // mid-reply with all fields at their maximum, then a bad checksum
      directed[0] = mk_row(KIND_TX_READY, 8'h00, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[1] = mk_row(KIND_RX_BYTE, 8'h55, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[2] = mk_row(KIND_RX_BYTE, 8'hAA, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[3] = mk_row(KIND_RX_BYTE, 8'h00, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[4] = mk_row(KIND_RX_BYTE, 8'h00, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[5] = mk_row(KIND_RX_BYTE, 8'hAA, 10'h155, 10'h2AA, 16'h1234, 16'hFEDC,
         1'b1, CMD_DEFAULT_OFFSET);
      directed[6] = mk_row(KIND_TX_READY, 8'hFF, 10'h3FF, 10'h3FF, 16'hFFFF, 16'hFFFF,
         1'b0, NO_OUTPUT);
      directed[7] = mk_row(KIND_TX_READY, 8'h00, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b0, NO_OUTPUT);
      directed[8] = mk_row(KIND_RX_BYTE, 8'hAA, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[9] = mk_row(KIND_RX_BYTE, 8'hFF, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[10] = mk_row(KIND_RX_BYTE, 8'hFF, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[11] = mk_row(KIND_RX_BYTE, 8'hA8, 10'h3FF, 10'h3FF, 16'hFFFF, 16'hFFFF,
         1'b1, CMD_MAX_PULSE);
      for (int i = 12; i < 21; i++) begin
         directed[i] = mk_row(KIND_TX_READY, 8'h5A, 10'h000, 10'h000, 16'h0000,
            16'h0000, 1'b0, NO_OUTPUT);
      end
      directed[21] = mk_row(KIND_RX_BYTE, 8'hAA, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[22] = mk_row(KIND_RX_BYTE, 8'h01, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[23] = mk_row(KIND_RX_BYTE, 8'h02, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, NO_OUTPUT);
      directed[24] = mk_row(KIND_RX_BYTE, 8'h00, 10'h000, 10'h000, 16'h0000, 16'h0000,
         1'b1, CMD_REJECTED);

      // Hold reset, then release it for good
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_request(directed[i].item, directed[i].typed, directed[i].want);
      end

      // Lowest settings: zero sync byte, zero offset
      drain_link();
      write_settings(8'h00, 16'h0000);
      run_random_phase(200);

      // Highest settings: offset wraps the compare value of every nonzero pulse
      drain_link();
      write_settings(8'hFF, 16'hFFFF);
      run_random_phase(200);

      drain_link();
      write_settings(8'($urandom), 16'($urandom));
      run_random_phase(250);

      drain_link();
      write_settings(8'($urandom), 16'($urandom));
      run_random_phase(250);

      // Back to reset values and drop all idling for the last stretch
      drain_link();
      write_settings(SYNC_RESET, OFFSET_RESET);
      quiet = 1'b1;
      run_random_phase(250);

      drain_link();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
